>>> hdl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and codes of the command line tokenizer: result encoding,
// the per-byte result bundle and the bundle queue sizing.
// ----------------------------------------------------------------------------
package clt_pkg;

   // Result slots in one bundle; one input byte causes at most four results
   localparam int MaxRes   = 5;
   localparam int ResIdxW  = $clog2(MaxRes);
   localparam int ResCntW  = $clog2(MaxRes + 1);

   // Bundle queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Token type codes
   localparam logic [2:0] TypeInt   = 3'd0;
   localparam logic [2:0] TypeReal  = 3'd1;
   localparam logic [2:0] TypeStr   = 3'd2;
   localparam logic [2:0] TypeKey   = 3'd3;
   localparam logic [2:0] TypeEqual = 3'd4;

   // Warning codes
   localparam logic [2:0] WarnNone     = 3'd0;
   localparam logic [2:0] WarnIllegal  = 3'd1;
   localparam logic [2:0] WarnExtraPt  = 3'd2;
   localparam logic [2:0] WarnReplaced = 3'd3;
   localparam logic [2:0] WarnQuote    = 3'd4;

   // One result transaction
   typedef struct packed {
      logic       has_char;
      logic [7:0] token_char;
      logic       token_end;
      logic [2:0] token_type;
      logic [2:0] warning;
      logic       line_end;
   } result_type;

   // All results caused by one input byte, oldest in item 0
   typedef struct packed {
      logic [ResCntW-1:0]           count;
      result_type [MaxRes-1:0]      items;
   } bundle_type;

endpackage

>>> hdl/clt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_front
// Lexer front end: takes one byte per cycle while the queue is not full,
// advances the lexer state and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module clt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_line_byte,
   input  logic                q_full,
   output logic                req_full,
   output logic                enq,
   output clt_pkg::bundle_type enq_bundle
);
   import clt_pkg::*;

   typedef enum logic [4:0] {
      ModeIdle = 5'b00001,
      ModeDot  = 5'b00010,
      ModeNum  = 5'b00100,
      ModeStr  = 5'b01000,
      ModeKey  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [1:0][7:0] bytes;
      logic [1:0]      cnt;
   } held_type;

   localparam logic [7:0] ChNul    = 8'h00;
   localparam logic [7:0] ChSpace  = " ";
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChEqual  = "=";
   localparam logic [7:0] ChComma  = ",";
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChMinus  = "-";
   localparam logic [7:0] ChPoint  = ".";
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChQuery  = "?";
   localparam logic [7:0] ChSlash  = "/";
   localparam logic [7:0] ChLbrk   = "[";
   localparam logic [7:0] ChRbrk   = "]";
   localparam logic [7:0] ChZero   = "0";
   localparam logic [7:0] ChNine   = "9";
   localparam logic [7:0] ChLowA   = "a";
   localparam logic [7:0] ChLowZ   = "z";
   localparam logic [7:0] ChUpA    = "A";
   localparam logic [7:0] ChUpZ    = "Z";

   function automatic logic is_dig(logic [7:0] c);
      return (c >= ChZero) && (c <= ChNine);
   endfunction

   function automatic logic is_alp(logic [7:0] c);
      return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ));
   endfunction

   function automatic logic is_spc(logic [7:0] c);
      return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
   endfunction

   function automatic logic ends_kw(logic [7:0] c);
      return (c == ChNul) || is_spc(c) || (c == ChEqual) || (c == ChComma) ||
             (c == ChBslash);
   endfunction

   // Append one result to a bundle
   function automatic bundle_type put_res(bundle_type b, logic has, logic [7:0] ch,
                                          logic tend, logic [2:0] ttype,
                                          logic [2:0] warn, logic lend);
      result_type r;
      r.has_char   = has;
      r.token_char = ch;
      r.token_end  = tend;
      r.token_type = ttype;
      r.warning    = warn;
      r.line_end   = lend;
      if (b.count < ResCntW'(MaxRes)) begin
         b.items[b.count[ResIdxW-1:0]] = r;
         b.count = b.count + ResCntW'(1);
      end
      return b;
   endfunction

   function automatic held_type hold_byte(held_type h, logic [7:0] c);
      if (h.cnt < 2'd2) begin
         h.bytes[h.cnt[0]] = c;
         h.cnt = h.cnt + 2'd1;
      end
      return h;
   endfunction

   function automatic logic [1:0] held_n(held_type h);
      return (h.cnt > 2'd2) ? 2'd2 : h.cnt;
   endfunction

   // Release held characters as plain token characters
   function automatic bundle_type emit_held(bundle_type b, held_type h);
      logic [1:0] n;
      n = held_n(h);
      for (int i = 0; i < 2; i++) begin
         if (2'(i) < n) b = put_res(b, 1'b1, h.bytes[i], 1'b0, TypeInt, WarnNone, 1'b0);
      end
      return b;
   endfunction

   // Release held characters, the last one closing the token
   function automatic bundle_type close_held(bundle_type b, held_type h,
                                             logic [2:0] ttype, logic [2:0] warn);
      logic [1:0] n;
      logic       last;
      n = held_n(h);
      if (n == 2'd0) begin
         b = put_res(b, 1'b0, ChNul, 1'b1, ttype, warn, 1'b0);
      end else begin
         for (int i = 0; i < 2; i++) begin
            last = (2'(i) == n - 2'd1);
            if (2'(i) < n) begin
               b = put_res(b, 1'b1, h.bytes[i], last, last ? ttype : TypeInt,
                           last ? warn : WarnNone, 1'b0);
            end
         end
      end
      return b;
   endfunction

   mode_type        mode_ff, mode_in;
   logic [1:0][7:0] held_bytes_ff, held_bytes_in;
   logic [1:0]      held_cnt_ff, held_cnt_in;
   logic            real_ff, real_in;
   logic            digit_ff, digit_in;

   held_type   h;
   bundle_type bnd;
   logic       go_between;
   logic       accept;
   logic [7:0] c;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign c        = req_line_byte;

   // Work out next lexer state and the results of this byte
   always_comb begin
      h.bytes    = held_bytes_ff;
      h.cnt      = held_cnt_ff;
      mode_in    = mode_ff;
      real_in    = real_ff;
      digit_in   = digit_ff;
      bnd        = '0;
      go_between = 1'b0;
      case (mode_ff)
         ModeDot: begin
            if (is_dig(c)) begin
               mode_in  = ModeNum;
               real_in  = 1'b1;
               digit_in = 1'b1;
               bnd      = emit_held(bnd, h);
               h.cnt    = 2'd0;
               h        = hold_byte(h, c);
            end else if (ends_kw(c)) begin
               bnd        = close_held(bnd, h, TypeKey, WarnNone);
               h.cnt      = 2'd0;
               go_between = 1'b1;
            end else begin
               bnd     = emit_held(bnd, h);
               h.cnt   = 2'd0;
               h       = hold_byte(h, c);
               mode_in = ModeKey;
            end
         end
         ModeNum: begin
            if (is_dig(c)) begin
               digit_in = 1'b1;
               bnd      = emit_held(bnd, h);
               h.cnt    = 2'd0;
               h        = hold_byte(h, c);
            end else if (c == ChPoint) begin
               if (real_ff) begin
                  bnd = put_res(bnd, 1'b0, ChNul, 1'b0, TypeInt, WarnExtraPt, 1'b0);
               end else begin
                  real_in = 1'b1;
                  if (digit_ff) begin
                     bnd   = emit_held(bnd, h);
                     h.cnt = 2'd0;
                  end
                  h = hold_byte(h, c);
               end
            end else begin
               // Close the number; a digitless one becomes 0.0
               if (!digit_ff) begin
                  bnd = put_res(bnd, 1'b1, ChZero, 1'b0, TypeInt, WarnReplaced, 1'b0);
                  bnd = put_res(bnd, 1'b1, ChPoint, 1'b0, TypeInt, WarnNone, 1'b0);
                  bnd = put_res(bnd, 1'b1, ChZero, 1'b1,
                                real_ff ? TypeReal : TypeInt, WarnNone, 1'b0);
               end else begin
                  bnd = close_held(bnd, h, real_ff ? TypeReal : TypeInt, WarnNone);
               end
               h.cnt      = 2'd0;
               mode_in    = ModeIdle;
               go_between = (c != ChMinus);
            end
         end
         ModeStr: begin
            if (c == ChQuote) begin
               bnd     = close_held(bnd, h, TypeStr, WarnNone);
               h.cnt   = 2'd0;
               mode_in = ModeIdle;
            end else if (c == ChNul) begin
               bnd        = close_held(bnd, h, TypeStr, WarnQuote);
               h.cnt      = 2'd0;
               go_between = 1'b1;
            end else begin
               bnd   = emit_held(bnd, h);
               h.cnt = 2'd0;
               h     = hold_byte(h, c);
            end
         end
         ModeKey: begin
            if (ends_kw(c)) begin
               bnd        = close_held(bnd, h, TypeKey, WarnNone);
               h.cnt      = 2'd0;
               go_between = 1'b1;
            end else begin
               bnd   = emit_held(bnd, h);
               h.cnt = 2'd0;
               h     = hold_byte(h, c);
            end
         end
         default: begin
            go_between = 1'b1;
         end
      endcase

      // Handle a byte seen between tokens
      if (go_between) begin
         h.cnt   = 2'd0;
         mode_in = ModeIdle;
         if (c == ChNul) begin
            bnd = put_res(bnd, 1'b0, ChNul, 1'b0, TypeInt, WarnNone, 1'b1);
         end else if (c == ChEqual) begin
            bnd = put_res(bnd, 1'b1, ChEqual, 1'b1, TypeEqual, WarnNone, 1'b0);
         end else if ((c == ChMinus) || is_dig(c)) begin
            mode_in  = ModeNum;
            real_in  = 1'b0;
            digit_in = is_dig(c);
            h        = hold_byte(h, c);
         end else if (c == ChPoint) begin
            mode_in = ModeDot;
            h       = hold_byte(h, c);
         end else if (c == ChQuote) begin
            mode_in = ModeStr;
         end else if (is_alp(c) || (c == ChQuery) || (c == ChSlash) ||
                      (c == ChLbrk) || (c == ChRbrk)) begin
            mode_in = ModeKey;
            h       = hold_byte(h, c);
         end else if (!is_spc(c) && (c != ChComma)) begin
            bnd = put_res(bnd, 1'b0, ChNul, 1'b0, TypeInt, WarnIllegal, 1'b0);
         end
      end

      held_bytes_in = h.bytes;
      held_cnt_in   = h.cnt;
   end

   assign enq        = accept && (bnd.count != '0);
   assign enq_bundle = bnd;

   // Advance lexer state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ModeIdle;
         held_cnt_ff <= 2'd0;
         real_ff     <= 1'b0;
         digit_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         held_cnt_ff <= held_cnt_in;
         real_ff     <= real_in;
         digit_ff    <= digit_in;
      end
   end

   // Held characters carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         held_bytes_ff <= held_bytes_in;
      end
   end

endmodule

>>> hdl/clt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_queue
// Short queue of result bundles between the lexer front end and the
// result sequencer.
// ----------------------------------------------------------------------------
module clt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                enq,
   input  clt_pkg::bundle_type enq_bundle,
   input  logic                deq,
   output logic                q_full,
   output logic                head_valid,
   output clt_pkg::bundle_type head_bundle
);
   import clt_pkg::*;

   bundle_type           slots_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] cnt_ff, cnt_in;
   logic                 do_enq, do_deq;

   assign q_full      = (cnt_ff == QueueCntW'(QueueDepth));
   assign head_valid  = (cnt_ff != '0);
   assign head_bundle = slots_ff[rd_ptr_ff];
   assign do_enq      = enq && !q_full;
   assign do_deq      = deq && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_enq ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_enq && !do_deq) begin
         cnt_in = cnt_ff + QueueCntW'(1);
      end else if (do_deq && !do_enq) begin
         cnt_in = cnt_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store an incoming bundle
   always_ff @(posedge clock) begin
      if (do_enq) begin
         slots_ff[wr_ptr_ff] <= enq_bundle;
      end
   end

endmodule

>>> hdl/clt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_back
// Result sequencer: walks the head bundle one result per pop and retires
// the bundle after its last result.
// ----------------------------------------------------------------------------
module clt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  clt_pkg::bundle_type head_bundle,
   input  logic                rsp_pop,
   output logic                deq,
   output logic                rsp_empty,
   output clt_pkg::result_type rsp_item
);
   import clt_pkg::*;

   logic [ResIdxW-1:0] idx_ff, idx_in;
   logic               take;
   logic               last;

   assign rsp_empty = !head_valid;
   assign rsp_item  = head_bundle.items[idx_ff];
   assign take      = rsp_pop && head_valid;
   assign last      = (ResCntW'(idx_ff) == head_bundle.count - ResCntW'(1));
   assign deq       = take && last;

   // Step to the next result, wrap on retiring the bundle
   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? '0 : idx_ff + ResIdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> hdl/command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Command line tokenizer: byte stream in, token characters with type marks
// and warnings out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive req_line_byte with req_push;
//   a transaction is taken on a clock edge where req_push is high and
//   req_full is low. Byte 0 ends the line; the next byte starts a new one.
//   Result side is a queue read port: while rsp_empty is low the oldest
//   result sits on the rsp_ ports and is taken when rsp_pop is high.
//   Each result is registered in the bundle queue ahead of the rsp_ ports.
//   Input takes one byte per cycle while req_full is low; a byte causes
//   zero to four results, sent one per cycle while rsp_pop is high. The
//   single read port sets the rate, so multi-result bytes slow input.
//   A four-entry bundle queue decouples the lexer from the result port:
//   when the receiver stalls, input is taken until the queue fills, then
//   req_full rises.
//   Reset (synchronous, active high) empties the queue and returns the lexer
//   to the between-tokens state; nothing is emitted from before reset.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_line_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic       rsp_has_char,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_end,
   output logic [2:0] rsp_token_type,
   output logic [2:0] rsp_warning,
   output logic       rsp_line_end
);
   import clt_pkg::*;

   logic       q_full;
   logic       enq;
   bundle_type enq_bundle;
   logic       deq;
   logic       head_valid;
   bundle_type head_bundle;
   result_type rsp_item;

   // Lexer front end
   clt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_line_byte (req_line_byte),
      .q_full        (q_full),
      .req_full      (req_full),
      .enq           (enq),
      .enq_bundle    (enq_bundle)
   );

   // Bundle queue
   clt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .enq         (enq),
      .enq_bundle  (enq_bundle),
      .deq         (deq),
      .q_full      (q_full),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   // Result sequencer
   clt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .rsp_pop     (rsp_pop),
      .deq         (deq),
      .rsp_empty   (rsp_empty),
      .rsp_item    (rsp_item)
   );

   assign rsp_has_char   = rsp_item.has_char;
   assign rsp_token_char = rsp_item.token_char;
   assign rsp_token_end  = rsp_item.token_end;
   assign rsp_token_type = rsp_item.token_type;
   assign rsp_warning    = rsp_item.warning;
   assign rsp_line_end   = rsp_item.line_end;

   // Nothing left to deliver straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // Input can only back up when results are waiting
   a_full_has_data: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled with no result waiting");

   // End of line travels on a result of its own
   a_line_end_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_line_end) |->
         (!rsp_has_char && !rsp_token_end && (rsp_warning == WarnNone)))
      else $error("line end result carries other fields");

   // A type is given only where a token closes
   a_type_at_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_token_end) |-> (rsp_token_type == TypeInt))
      else $error("token type outside token end");

endmodule

>>> test/tb_command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_line_tokenizer_top
// Self-checking bench for the command line tokenizer. Byte streams are pushed
// into the block while a local lexer predicts the token results each byte
// should cause; every popped result is matched against the oldest prediction.
// Covers a directed line of corner cases, a receiver stall that fills the
// block, and random well-formed lines mixed with noise.
// ----------------------------------------------------------------------------
module tb_command_line_tokenizer_top;
   import clt_pkg::*;

   localparam logic [2:0] NoType = 3'd0;
   localparam int StallCycles = 80;

   typedef enum logic [2:0] {
      LexIdle = 3'd0,
      LexDot  = 3'd1,
      LexNum  = 3'd2,
      LexStr  = 3'd3,
      LexKey  = 3'd4
   } lex_mode_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_line_byte = 8'h00;
   logic       req_full;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   logic       rsp_has_char;
   logic [7:0] rsp_token_char;
   logic       rsp_token_end;
   logic [2:0] rsp_token_type;
   logic [2:0] rsp_warning;
   logic       rsp_line_end;

   // Predicted lexer state
   lex_mode_type lex_mode = LexIdle;
   logic [7:0] held_bytes [2];
   int         held_count = 0;
   bit         number_is_real = 1'b0;
   bit         digit_seen = 1'b0;

   result_type token_results_due [$];
   result_type arrived;
   result_type wanted;
   int         mismatch_count = 0;
   int         counted_bytes = 0;

   // Flow control shared by sender and receiver
   bit         steady = 1'b0;
   int         stall_asks = 0;
   int         stall_seen = 0;
   int         stall_count = 0;

   command_line_tokenizer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_line_byte  (req_line_byte),
      .req_full       (req_full),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_has_char   (rsp_has_char),
      .rsp_token_char (rsp_token_char),
      .rsp_token_end  (rsp_token_end),
      .rsp_token_type (rsp_token_type),
      .rsp_warning    (rsp_warning),
      .rsp_line_end   (rsp_line_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Character classes
   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_space(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic bit ends_keyword(logic [7:0] b);
      return b == 8'h00 || is_space(b) || b == "=" || b == "," || b == "\\";
   endfunction

   // Queue one predicted result
   function automatic void put_result(bit has, logic [7:0] ch, bit fin, logic [2:0] kind,
                                      logic [2:0] warn, bit eol);
      result_type r;
      r.has_char   = has;
      r.token_char = ch;
      r.token_end  = fin;
      r.token_type = kind;
      r.warning    = warn;
      r.line_end   = eol;
      token_results_due.push_back(r);
   endfunction

   function automatic void hold_byte(logic [7:0] b);
      if (held_count < 2) begin
         held_bytes[held_count] = b;
         held_count++;
      end
   endfunction

   function automatic void flush_held();
      int i;
      for (i = 0; i < held_count; i++) put_result(1'b1, held_bytes[i], 1'b0, NoType, WarnNone, 1'b0);
      held_count = 0;
   endfunction

   // Release held characters, marking the last one as the token's end
   function automatic void close_held(logic [2:0] kind, logic [2:0] warn);
      int  i;
      bit  last;
      if (held_count == 0) begin
         put_result(1'b0, 8'h00, 1'b1, kind, warn, 1'b0);
      end else begin
         for (i = 0; i < held_count; i++) begin
            last = (i == held_count - 1);
            put_result(1'b1, held_bytes[i], last, last ? kind : NoType,
                       last ? warn : WarnNone, 1'b0);
         end
      end
      held_count = 0;
   endfunction

   // Close a number; a digitless one is replaced by 0.0
   function automatic void close_number();
      if (!digit_seen) begin
         held_count = 0;
         put_result(1'b1, "0", 1'b0, NoType, WarnReplaced, 1'b0);
         put_result(1'b1, ".", 1'b0, NoType, WarnNone, 1'b0);
         put_result(1'b1, "0", 1'b1, number_is_real ? TypeReal : TypeInt, WarnNone, 1'b0);
      end else begin
         close_held(number_is_real ? TypeReal : TypeInt, WarnNone);
      end
      lex_mode = LexIdle;
   endfunction

   // Byte seen between tokens: start a token, skip or flag it
   function automatic void lex_between(logic [7:0] b);
      held_count = 0;
      lex_mode   = LexIdle;
      if (b == 8'h00) begin
         put_result(1'b0, 8'h00, 1'b0, NoType, WarnNone, 1'b1);
      end else if (b == "=") begin
         put_result(1'b1, "=", 1'b1, TypeEqual, WarnNone, 1'b0);
      end else if (b == "-" || is_digit(b)) begin
         lex_mode       = LexNum;
         number_is_real = 1'b0;
         digit_seen     = is_digit(b);
         hold_byte(b);
      end else if (b == ".") begin
         lex_mode = LexDot;
         hold_byte(b);
      end else if (b == "\"") begin
         lex_mode = LexStr;
      end else if (is_alpha(b) || b == "?" || b == "/" || b == "[" || b == "]") begin
         lex_mode = LexKey;
         hold_byte(b);
      end else if (!is_space(b) && b != ",") begin
         put_result(1'b0, 8'h00, 1'b0, NoType, WarnIllegal, 1'b0);
      end
   endfunction

   // Advance the predicted lexer by one accepted byte
   function automatic void lex_byte(logic [7:0] b);
      case (lex_mode)
         LexDot: begin
            if (is_digit(b)) begin
               lex_mode       = LexNum;
               number_is_real = 1'b1;
               digit_seen     = 1'b1;
               flush_held();
               hold_byte(b);
            end else if (ends_keyword(b)) begin
               close_held(TypeKey, WarnNone);
               lex_between(b);
            end else begin
               flush_held();
               hold_byte(b);
               lex_mode = LexKey;
            end
         end
         LexNum: begin
            if (is_digit(b)) begin
               digit_seen = 1'b1;
               flush_held();
               hold_byte(b);
            end else if (b == ".") begin
               if (number_is_real) begin
                  put_result(1'b0, 8'h00, 1'b0, NoType, WarnExtraPt, 1'b0);
               end else begin
                  number_is_real = 1'b1;
                  if (digit_seen) flush_held();
                  hold_byte(b);
               end
            end else if (b == "-") begin
               close_number();
            end else begin
               close_number();
               lex_between(b);
            end
         end
         LexStr: begin
            if (b == "\"") begin
               close_held(TypeStr, WarnNone);
               lex_mode = LexIdle;
            end else if (b == 8'h00) begin
               close_held(TypeStr, WarnQuote);
               lex_between(b);
            end else begin
               flush_held();
               hold_byte(b);
            end
         end
         LexKey: begin
            if (ends_keyword(b)) begin
               close_held(TypeKey, WarnNone);
               lex_between(b);
            end else begin
               flush_held();
               hold_byte(b);
            end
         end
         default: lex_between(b);
      endcase
   endfunction

   // Push one byte, idling at random beforehand unless steady, and predict once it is taken
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_line_byte <= b;
      do @(posedge clock); while (req_full);
      lex_byte(b);
      counted_bytes++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_terminator();
      case ($urandom_range(0, 7))
         0:       return "-";
         1:       return "=";
         2:       return ",";
         3:       return 8'h00;
         4:       return 8'(9 + $urandom_range(0, 4));
         5:       return 8'($urandom_range(1, 255));
         default: return " ";
      endcase
   endfunction

   // Receiver: random or steady pops, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (stall_asks != stall_seen) begin
         stall_seen  <= stall_asks;
         stall_count <= StallCycles;
         rsp_pop     <= 1'b0;
      end else if (stall_count > 0) begin
         stall_count <= stall_count - 1;
         rsp_pop     <= 1'b0;
      end else begin
         rsp_pop <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   // Match every popped transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         arrived = '{rsp_has_char, rsp_token_char, rsp_token_end, rsp_token_type,
                     rsp_warning, rsp_line_end};
         if (token_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result has=%0d char=%02h end=%0d type=%0d warn=%0d le=%0d",
                        arrived.has_char, arrived.token_char, arrived.token_end,
                        arrived.token_type, arrived.warning, arrived.line_end);
         end else begin
            wanted = token_results_due.pop_front();
            if (arrived !== wanted) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: expected has=%0d char=%02h end=%0d type=%0d warn=%0d le=%0d",
                           wanted.has_char, wanted.token_char, wanted.token_end,
                           wanted.token_type, wanted.warning, wanted.line_end);
                  $display("       actual   has=%0d char=%02h end=%0d type=%0d warn=%0d le=%0d",
                           arrived.has_char, arrived.token_char, arrived.token_end,
                           arrived.token_type, arrived.warning, arrived.line_end);
               end
            end
         end
      end
   end

   // One line through every token kind and each corner case
   task automatic test_directed_line();
      send_text("=12 -.5.6-\"\"-.,.x\\");
      send_byte(8'hFF);
      send_text("- \"a");
      send_byte(8'h00);
   endtask

   // Hold the receiver off while a long keyword keeps arriving
   task automatic test_backpressure();
      steady = 1'b1;
      stall_asks++;
      send_text("abcdefghijklmnopqrstuvwxyz0123 ");
      send_byte(8'h00);
      steady = 1'b0;
   endtask

   // Random lines of well-formed tokens with random content, plus noise
   task automatic test_random_lines(input int items_wanted, input bit no_gaps);
      int         goal;
      int         len;
      int         i;
      logic [7:0] b;
      steady = no_gaps;
      goal   = counted_bytes + items_wanted;
      while (counted_bytes < goal) begin
         case ($urandom_range(0, 11))
            0, 1, 2: begin
               if ($urandom_range(0, 2) == 0) send_byte("-");
               len = $urandom_range(0, 5);
               for (i = 0; i < len; i++)
                  send_byte(($urandom_range(0, 4) == 0) ? 8'("." ) : 8'("0" + $urandom_range(0, 9)));
               send_byte(pick_terminator());
            end
            3, 4: begin
               case ($urandom_range(0, 5))
                  0:       send_byte("?");
                  1:       send_byte("/");
                  2:       send_byte($urandom_range(0, 1) ? 8'("[") : 8'("]"));
                  3:       send_byte(".");
                  default: send_byte(8'("a" + $urandom_range(0, 25)));
               endcase
               len = $urandom_range(0, 5);
               for (i = 0; i < len; i++) begin
                  case ($urandom_range(0, 5))
                     0:       b = 8'("0" + $urandom_range(0, 9));
                     1:       b = ($urandom_range(0, 1)) ? 8'(".") : 8'("-");
                     2:       b = 8'($urandom_range(1, 255));
                     default: b = 8'("A" + $urandom_range(0, 25));
                  endcase
                  send_byte(b);
               end
               send_byte(pick_terminator());
            end
            5, 6: begin
               send_byte("\"");
               len = $urandom_range(0, 6);
               for (i = 0; i < len; i++) begin
                  b = 8'($urandom_range(1, 255));
                  if (b == "\"") b = "'";
                  send_byte(b);
               end
               send_byte(($urandom_range(0, 5) == 0) ? 8'h00 : 8'("\""));
            end
            7:    send_byte("=");
            8, 9: send_byte(($urandom_range(0, 1)) ? 8'(" ") : 8'(","));
            10:   send_byte(8'($urandom_range(0, 255)));
            default: send_byte(8'h00);
         endcase
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_line();
      test_backpressure();
      test_random_lines(40, 1'b1);
      test_random_lines(130, 1'b0);
      // Stop offering, then wait for every predicted result
      req_push <= 1'b0;
      while (token_results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("command_line_tokenizer_top test passed");
      else
         $display("command_line_tokenizer_top test failed");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("command_line_tokenizer_top test failed");
      $finish;
   end

endmodule

>>> command_line_tokenizer_top.f
hdl/clt_pkg.sv
hdl/clt_front.sv
hdl/clt_queue.sv
hdl/clt_back.sv
hdl/command_line_tokenizer_top.sv
test/tb_command_line_tokenizer_top.sv
